>>> rtl/ale_pkg.sv
package ale_pkg;

    // Field widths of the request and response items.
    localparam int OPC_W   = 3;
    localparam int POS_W   = 7;
    localparam int VAL_W   = 32;
    localparam int ST_W    = 2;
    localparam int FOUND_W = 7;
    localparam int CNT_W   = 7;

    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_DATA_WIDTH = 32;

    // Opcodes.
    localparam logic [OPC_W-1:0] OP_INSERT     = 3'd0;
    localparam logic [OPC_W-1:0] OP_ERASE      = 3'd1;
    localparam logic [OPC_W-1:0] OP_FIND       = 3'd2;
    localparam logic [OPC_W-1:0] OP_PUSH_BACK  = 3'd3;
    localparam logic [OPC_W-1:0] OP_POP_BACK   = 3'd4;
    localparam logic [OPC_W-1:0] OP_PUSH_FRONT = 3'd5;
    localparam logic [OPC_W-1:0] OP_POP_FRONT  = 3'd6;
    localparam logic [OPC_W-1:0] OP_CLEAR      = 3'd7;

    // Response status codes.
    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD  = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL = 2'd2;

    localparam logic [FOUND_W-1:0] NO_MATCH = 7'h7F;

    // Index register operations.
    localparam logic [2:0] IDX_HOLD       = 3'd0;
    localparam logic [2:0] IDX_LOAD_COUNT = 3'd1;
    localparam logic [2:0] IDX_LOAD_POS1  = 3'd2;
    localparam logic [2:0] IDX_LOAD_ZERO  = 3'd3;
    localparam logic [2:0] IDX_INC        = 3'd4;
    localparam logic [2:0] IDX_DEC        = 3'd5;

    // Memory write sources and targets.
    localparam logic [1:0] WR_IDX_FROM_RD   = 2'd0;
    localparam logic [1:0] WR_IDXM1_FROM_RD = 2'd1;
    localparam logic [1:0] WR_POS_VALUE     = 2'd2;

    // Entry count operations.
    localparam logic [1:0] CNT_HOLD = 2'd0;
    localparam logic [1:0] CNT_INC  = 2'd1;
    localparam logic [1:0] CNT_DEC  = 2'd2;
    localparam logic [1:0] CNT_CLR  = 2'd3;

    typedef struct packed {
        logic             take;
        logic [2:0]       idx_op;
        logic             rd_en;
        logic             rd_prev;
        logic             wr_en;
        logic [1:0]       wr_mode;
        logic [1:0]       cnt_op;
        logic             st_en;
        logic [ST_W-1:0]  st_code;
        logic             found_en;
        logic             out_load;
    } t_cmd;

    typedef struct packed {
        logic [OPC_W-1:0] op;
        logic             pos_bad_ins;
        logic             pos_bad_era;
        logic             full;
        logic             empty;
        logic             idx_gt_pos;
        logic             idx_lt_count;
        logic             match;
        logic             out_free;
    } t_stat;

endpackage

>>> rtl/ale_req_if.sv
interface ale_req_if
    import ale_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [OPC_W-1:0] opcode;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value;

    modport source (output valid, output opcode, output position, output value, input ready);
    modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface

>>> rtl/ale_rsp_if.sv
interface ale_rsp_if
    import ale_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [ST_W-1:0]    status;
    logic [FOUND_W-1:0] found_index;
    logic [CNT_W-1:0]   count;

    modport source (output valid, output status, output found_index, output count, input ready);
    modport sink   (input valid, input status, input found_index, input count, output ready);
endinterface

>>> rtl/ale_ctrl.sv
module ale_ctrl
    import ale_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_req_valid,
    input  t_stat i_stat,
    output logic  o_req_ready,
    output t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_SHUP_CHK = 4'd2;
    localparam logic [3:0] S_SHUP_WR  = 4'd3;
    localparam logic [3:0] S_SHDN_CHK = 4'd4;
    localparam logic [3:0] S_SHDN_WR  = 4'd5;
    localparam logic [3:0] S_FIND_CHK = 4'd6;
    localparam logic [3:0] S_FIND_CMP = 4'd7;
    localparam logic [3:0] S_FINISH   = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_state = S_FINISH;
                unique case (i_stat.op)
                    OP_INSERT: begin
                        if (i_stat.pos_bad_ins) begin
                            o_cmd.st_en   = 1'b1;
                            o_cmd.st_code = ST_BAD;
                        end else if (i_stat.full) begin
                            o_cmd.st_en   = 1'b1;
                            o_cmd.st_code = ST_FULL;
                        end else begin
                            o_cmd.idx_op = IDX_LOAD_COUNT;
                            n_state      = S_SHUP_CHK;
                        end
                    end
                    OP_PUSH_BACK, OP_PUSH_FRONT: begin
                        if (i_stat.full) begin
                            o_cmd.st_en   = 1'b1;
                            o_cmd.st_code = ST_FULL;
                        end else begin
                            o_cmd.idx_op = IDX_LOAD_COUNT;
                            n_state      = S_SHUP_CHK;
                        end
                    end
                    OP_ERASE: begin
                        if (i_stat.pos_bad_era) begin
                            o_cmd.st_en   = 1'b1;
                            o_cmd.st_code = ST_BAD;
                        end else begin
                            o_cmd.idx_op = IDX_LOAD_POS1;
                            n_state      = S_SHDN_CHK;
                        end
                    end
                    OP_POP_FRONT: begin
                        if (i_stat.empty) begin
                            o_cmd.st_en   = 1'b1;
                            o_cmd.st_code = ST_BAD;
                        end else begin
                            o_cmd.idx_op = IDX_LOAD_POS1;
                            n_state      = S_SHDN_CHK;
                        end
                    end
                    OP_POP_BACK: begin
                        if (i_stat.empty) begin
                            o_cmd.st_en   = 1'b1;
                            o_cmd.st_code = ST_BAD;
                        end else begin
                            o_cmd.cnt_op = CNT_DEC;
                        end
                    end
                    OP_FIND: begin
                        o_cmd.idx_op = IDX_LOAD_ZERO;
                        n_state      = S_FIND_CHK;
                    end
                    OP_CLEAR: begin
                        o_cmd.cnt_op = CNT_CLR;
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            // Open the gap from the top down, then drop the new entry in.
            S_SHUP_CHK: begin
                if (i_stat.idx_gt_pos) begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_prev = 1'b1;
                    n_state       = S_SHUP_WR;
                end else begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_mode = WR_POS_VALUE;
                    o_cmd.cnt_op  = CNT_INC;
                    n_state       = S_FINISH;
                end
            end
            S_SHUP_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_mode = WR_IDX_FROM_RD;
                o_cmd.idx_op  = IDX_DEC;
                n_state       = S_SHUP_CHK;
            end
            // Close the gap from the erased position upward.
            S_SHDN_CHK: begin
                if (i_stat.idx_lt_count) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_SHDN_WR;
                end else begin
                    o_cmd.cnt_op = CNT_DEC;
                    n_state      = S_FINISH;
                end
            end
            S_SHDN_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_mode = WR_IDXM1_FROM_RD;
                o_cmd.idx_op  = IDX_INC;
                n_state       = S_SHDN_CHK;
            end
            S_FIND_CHK: begin
                if (i_stat.idx_lt_count) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_FIND_CMP;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FIND_CMP: begin
                if (i_stat.match) begin
                    o_cmd.found_en = 1'b1;
                    n_state        = S_FINISH;
                end else begin
                    o_cmd.idx_op = IDX_INC;
                    n_state      = S_FIND_CHK;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/ale_dpath.sv
module ale_dpath
    import ale_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [OPC_W-1:0]   i_opcode,
    input  logic [POS_W-1:0]   i_position,
    input  logic [VAL_W-1:0]   i_value,
    input  logic               i_rsp_ready,
    output t_stat              o_stat,
    output logic               o_rsp_valid,
    output logic [ST_W-1:0]    o_status,
    output logic [FOUND_W-1:0] o_found_index,
    output logic [CNT_W-1:0]   o_count
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    logic [DATA_WIDTH-1:0] r_mem [CAPACITY];
    logic [DATA_WIDTH-1:0] r_rdata;
    logic [DATA_WIDTH-1:0] r_value;
    logic [OPC_W-1:0]      r_op;
    logic [PW-1:0]         r_pos;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_idx;
    logic [ST_W-1:0]       r_status;
    logic [FOUND_W-1:0]    r_found;
    logic                  r_o_valid;
    logic [ST_W-1:0]       r_o_status;
    logic [FOUND_W-1:0]    r_o_found;
    logic [CNT_W-1:0]      r_o_count;

    logic [63:0]           value_sx;
    logic [PW-1:0]         n_pos;
    logic [PW-1:0]         count_ext;
    logic [PW-1:0]         idx_ext;
    logic [PW-1:0]         pos_p1;
    logic [CW-1:0]         idx_m1;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;

    // The 32-bit value is sign-extended, then cut to the stored width.
    assign value_sx  = {{32{i_value[VAL_W-1]}}, i_value};
    assign count_ext = PW'(r_count);
    assign idx_ext   = PW'(r_idx);
    assign pos_p1    = r_pos + 1'b1;
    assign idx_m1    = r_idx - 1'b1;

    always_comb begin
        unique case (i_opcode)
            OP_PUSH_BACK:               n_pos = count_ext;
            OP_PUSH_FRONT, OP_POP_FRONT: n_pos = '0;
            default:                    n_pos = PW'(i_position);
        endcase
    end

    assign rd_addr = i_cmd.rd_prev ? idx_m1[AW-1:0] : r_idx[AW-1:0];

    always_comb begin
        unique case (i_cmd.wr_mode)
            WR_IDX_FROM_RD: begin
                wr_addr = r_idx[AW-1:0];
                wr_data = r_rdata;
            end
            WR_IDXM1_FROM_RD: begin
                wr_addr = idx_m1[AW-1:0];
                wr_data = r_rdata;
            end
            default: begin
                wr_addr = r_pos[AW-1:0];
                wr_data = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_op     <= i_opcode;
            r_pos    <= n_pos;
            r_value  <= value_sx[DATA_WIDTH-1:0];
            r_status <= ST_OK;
            r_found  <= NO_MATCH;
        end else begin
            if (i_cmd.st_en) begin
                r_status <= i_cmd.st_code;
            end
            if (i_cmd.found_en) begin
                r_found <= idx_ext[FOUND_W-1:0];
            end
        end

        unique case (i_cmd.idx_op)
            IDX_LOAD_COUNT: r_idx <= r_count;
            IDX_LOAD_POS1:  r_idx <= pos_p1[CW-1:0];
            IDX_LOAD_ZERO:  r_idx <= '0;
            IDX_INC:        r_idx <= r_idx + 1'b1;
            IDX_DEC:        r_idx <= idx_m1;
            default:        r_idx <= r_idx;
        endcase

        if (i_cmd.out_load) begin
            r_o_status <= r_status;
            r_o_found  <= r_found;
            r_o_count  <= count_ext[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            unique case (i_cmd.cnt_op)
                CNT_INC: r_count <= r_count + 1'b1;
                CNT_DEC: r_count <= r_count - 1'b1;
                CNT_CLR: r_count <= '0;
                default: r_count <= r_count;
            endcase
            if (i_cmd.out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_stat.op           = r_op;
    assign o_stat.pos_bad_ins  = (r_pos > count_ext);
    assign o_stat.pos_bad_era  = (r_pos >= count_ext);
    assign o_stat.full         = (r_count == CW'(CAPACITY));
    assign o_stat.empty        = (r_count == '0);
    assign o_stat.idx_gt_pos   = (idx_ext > r_pos);
    assign o_stat.idx_lt_count = (r_idx < r_count);
    assign o_stat.match        = (r_rdata == r_value);
    assign o_stat.out_free     = !r_o_valid || i_rsp_ready;

    assign o_rsp_valid   = r_o_valid;
    assign o_status      = r_o_status;
    assign o_found_index = r_o_found;
    assign o_count       = r_o_count;

endmodule

>>> rtl/array_list_engine_unit.sv
// Ordered list of up to CAPACITY signed entries in a single-port memory, one
// request in flight at a time. A request is taken only when the engine is idle,
// and its response goes into an output register, so the next request is taken
// while that response still waits. A request that only checks or changes the
// count (pop_back, clear, or any error) goes on straight to its response;
// insert and the pushes shift the entries from position up to the count up
// by one place; erase and pop_front shift the entries above position down by
// one place; a find compares entries from index zero on until a hit or the
// count. Each entry moved or compared is first read from the memory, then
// written or compared. Entries beyond the count are never read.
module array_list_engine_unit
    import ale_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ale_req_if.sink   i_req,
    ale_rsp_if.source o_rsp
);

    t_cmd  cmd;
    t_stat stat;

    ale_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_stat      (stat),
        .o_req_ready (i_req.ready),
        .o_cmd       (cmd)
    );

    ale_dpath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_opcode      (i_req.opcode),
        .i_position    (i_req.position),
        .i_value       (i_req.value),
        .i_rsp_ready   (o_rsp.ready),
        .o_stat        (stat),
        .o_rsp_valid   (o_rsp.valid),
        .o_status      (o_rsp.status),
        .o_found_index (o_rsp.found_index),
        .o_count       (o_rsp.count)
    );

endmodule
